>>> rtl/vdd_pkg.sv
`default_nettype none

package vdd_pkg;

  localparam int ITERATIONS      = 16;
  localparam int COMPONENT_WIDTH = 16;
  localparam int GUARD_BITS      = 8;
  localparam int TABLE_LEN       = 24;
  localparam int ITER_USED       = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

  localparam int XY_W    = COMPONENT_WIDTH + GUARD_BITS + 3;
  localparam int Z_W     = 32;
  localparam int ANGLE_W = 15;
  localparam int Q_W     = Z_W - 14;

  localparam int LATENCY = ITER_USED + 3;

  localparam logic [ANGLE_W-1:0] ANGLE_0   = ANGLE_W'(0);
  localparam logic [ANGLE_W-1:0] ANGLE_90  = ANGLE_W'(5760);
  localparam logic [ANGLE_W-1:0] ANGLE_180 = ANGLE_W'(11520);
  localparam logic [ANGLE_W-1:0] ANGLE_270 = ANGLE_W'(17280);
  localparam logic [Q_W-1:0]     FULL_TURN = Q_W'(23040);

  localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(180 * (1 << 20));
  localparam logic signed [Z_W-1:0] Z_ROUND     = Z_W'(8192);
  localparam logic signed [Z_W-1:0] Z_WRAP_RND  = Z_W'(360 * (1 << 20) + 8192);

  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] dir_x;
    logic signed [COMPONENT_WIDTH-1:0] dir_y;
  } in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               zero_vector;
  } out_t;

  typedef struct packed {
    logic                    valid;
    logic                    bypass;
    logic                    zero;
    logic [ANGLE_W-1:0]      byp_angle;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } cordic_t;

  typedef struct packed {
    logic               valid;
    logic               bypass;
    logic               zero;
    logic [ANGLE_W-1:0] byp_angle;
    logic [Z_W-1:0]     zr;
  } post_t;

  function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:       v = 32'sd47185920;
      1:       v = 32'sd27855475;
      2:       v = 32'sd14718068;
      3:       v = 32'sd7471121;
      4:       v = 32'sd3750058;
      5:       v = 32'sd1876857;
      6:       v = 32'sd938658;
      7:       v = 32'sd469357;
      8:       v = 32'sd234682;
      9:       v = 32'sd117342;
      10:      v = 32'sd58671;
      11:      v = 32'sd29335;
      12:      v = 32'sd14668;
      13:      v = 32'sd7334;
      14:      v = 32'sd3667;
      15:      v = 32'sd1833;
      16:      v = 32'sd917;
      17:      v = 32'sd458;
      18:      v = 32'sd229;
      19:      v = 32'sd115;
      20:      v = 32'sd57;
      21:      v = 32'sd29;
      22:      v = 32'sd14;
      23:      v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/vector_direction_to_degrees_core.sv
// Angle of a direction vector over the full circle, in units of 1/64 degree.
// Input channel: a transaction is accepted at a rising edge with start high
// and busy low. in_data carries dir_x and dir_y as signed Q2.14 values.
// busy is always low, so a new vector may be presented in every cycle.
// Result channel: out_valid is high for exactly one cycle per transaction,
// with out_data holding angle (0 to 23039) and zero_vector.
// The path holds one input register, one register per CORDIC micro-rotation,
// and two output stages.
// Throughput is one vector per cycle, set by the fully unrolled rotation
// pipeline in which each stage holds one shift-add step.
// Results leave in the order that vectors entered. The receiver cannot
// stall the block and must take every result in its strobe cycle.
// Axis-aligned and zero vectors bypass the rotation and give exact angles.
// A synchronous reset clears all valid bits; transactions in flight are
// dropped and no result appears until a new transaction is accepted.
`default_nettype none

module vector_direction_to_degrees_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire vdd_pkg::in_t in_data,
  output logic              out_valid,
  output vdd_pkg::out_t     out_data
);

  vdd_pkg::cordic_t pre_stage;
  vdd_pkg::cordic_t rot_stage;
  logic             accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  vdd_pre u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .stage_out (pre_stage)
  );

  vdd_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage_in  (pre_stage),
    .stage_out (rot_stage)
  );

  vdd_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage_in  (rot_stage),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(vdd_pkg::LATENCY) out_valid)
    else $error("accepted transaction produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, vdd_pkg::LATENCY))
    else $error("result without an accepted transaction");

  a_angle_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.angle < vdd_pkg::ANGLE_W'(23040)))
    else $error("angle outside full circle");

  a_zero_gives_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_vector) |-> (out_data.angle == vdd_pkg::ANGLE_0))
    else $error("zero vector with nonzero angle");
`endif

endmodule

`default_nettype wire

>>> rtl/vdd_pre.sv
`default_nettype none

module vdd_pre (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire vdd_pkg::in_t   in_data,
  output vdd_pkg::cordic_t    stage_out
);

  localparam int CW = vdd_pkg::COMPONENT_WIDTH;
  localparam int XW = vdd_pkg::XY_W;

  vdd_pkg::cordic_t stage_nxt;
  vdd_pkg::cordic_t stage_r;

  logic signed [XW-1:0] x_sc;
  logic signed [XW-1:0] y_sc;
  logic                 x_zero;
  logic                 y_zero;

  always_comb begin
    x_sc   = {{(XW-CW){in_data.dir_x[CW-1]}}, in_data.dir_x} <<< vdd_pkg::GUARD_BITS;
    y_sc   = {{(XW-CW){in_data.dir_y[CW-1]}}, in_data.dir_y} <<< vdd_pkg::GUARD_BITS;
    x_zero = (in_data.dir_x == '0);
    y_zero = (in_data.dir_y == '0);

    stage_nxt.valid     = accept;
    stage_nxt.zero      = x_zero && y_zero;
    stage_nxt.bypass    = x_zero || y_zero;
    stage_nxt.byp_angle = vdd_pkg::ANGLE_0;
    if (y_zero) begin
      stage_nxt.byp_angle = in_data.dir_x[CW-1] ? vdd_pkg::ANGLE_180 : vdd_pkg::ANGLE_0;
    end else if (x_zero) begin
      stage_nxt.byp_angle = in_data.dir_y[CW-1] ? vdd_pkg::ANGLE_270 : vdd_pkg::ANGLE_90;
    end

    if (in_data.dir_x[CW-1]) begin
      stage_nxt.x = -x_sc;
      stage_nxt.y = -y_sc;
      stage_nxt.z = vdd_pkg::Z_HALF_TURN;
    end else begin
      stage_nxt.x = x_sc;
      stage_nxt.y = y_sc;
      stage_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

`default_nettype wire

>>> rtl/vdd_cordic.sv
`default_nettype none

module vdd_cordic (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire vdd_pkg::cordic_t stage_in,
  output vdd_pkg::cordic_t      stage_out
);

  localparam int N = vdd_pkg::ITER_USED;

  wire vdd_pkg::cordic_t chain [0:N];

  assign chain[0] = stage_in;

  for (genvar i = 0; i < N; i++) begin : g_iter
    vdd_pkg::cordic_t st_nxt;
    vdd_pkg::cordic_t st_r;
    logic signed [vdd_pkg::XY_W-1:0] xs;
    logic signed [vdd_pkg::XY_W-1:0] ys;

    always_comb begin
      st_nxt = chain[i];
      xs     = chain[i].x >>> i;
      ys     = chain[i].y >>> i;
      if (!chain[i].y[vdd_pkg::XY_W-1]) begin
        st_nxt.x = chain[i].x + ys;
        st_nxt.y = chain[i].y - xs;
        st_nxt.z = chain[i].z + vdd_pkg::atan_entry(i);
      end else begin
        st_nxt.x = chain[i].x - ys;
        st_nxt.y = chain[i].y + xs;
        st_nxt.z = chain[i].z - vdd_pkg::atan_entry(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r.valid <= 1'b0;
      end else begin
        st_r <= st_nxt;
      end
    end

    assign chain[i+1] = st_r;
  end

  assign stage_out = chain[N];

endmodule

`default_nettype wire

>>> rtl/vdd_post.sv
`default_nettype none

module vdd_post (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire vdd_pkg::cordic_t stage_in,
  output logic                  out_valid,
  output vdd_pkg::out_t         out_data
);

  localparam int ZW = vdd_pkg::Z_W;
  localparam int QW = vdd_pkg::Q_W;

  vdd_pkg::post_t post_nxt;
  vdd_pkg::post_t post_r;
  logic           valid_r;
  vdd_pkg::out_t  out_nxt;
  vdd_pkg::out_t  out_r;
  logic [QW-1:0]  q;
  logic [QW-1:0]  q_wrap;

  always_comb begin
    post_nxt.valid     = stage_in.valid;
    post_nxt.bypass    = stage_in.bypass;
    post_nxt.zero      = stage_in.zero;
    post_nxt.byp_angle = stage_in.byp_angle;
    post_nxt.zr        = ZW'(stage_in.z + (stage_in.z[ZW-1] ? vdd_pkg::Z_WRAP_RND
                                                          : vdd_pkg::Z_ROUND));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_r.valid <= 1'b0;
    end else begin
      post_r <= post_nxt;
    end
  end

  always_comb begin
    q      = post_r.zr[ZW-1:14];
    q_wrap = (q >= vdd_pkg::FULL_TURN) ? (q - vdd_pkg::FULL_TURN) : q;
    out_nxt.zero_vector = post_r.zero;
    out_nxt.angle       = post_r.bypass ? post_r.byp_angle : q_wrap[vdd_pkg::ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= post_r.valid;
      out_r   <= out_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
